// ----- src/ogsb_pkg.sv -----
// ----------------------------------------------------------------------------
// ogsb_pkg
// Shared types and constants of the occupancy grid segment builder.
// ----------------------------------------------------------------------------
package ogsb_pkg;

    localparam int GRID_W           = 40;
    localparam int GRID_H           = 20;
    localparam int CELL_PIXELS      = 20;
    localparam int ROBOT_COLUMN     = 20;
    localparam int ROBOT_CELLS      = 2;
    localparam int FRONT_BLOCK_ROWS = 2;

    localparam int IMAGE_W  = 801;
    localparam int IMAGE_H  = 400;
    localparam int CENTRE_X = (GRID_W * CELL_PIXELS) / 2;

    localparam int FRONT_COL_L = ROBOT_COLUMN - ROBOT_CELLS / 2 - 2;
    localparam int FRONT_COL_R = ROBOT_COLUMN + ROBOT_CELLS / 2 + 1;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int GAIN_W  = 24;
    localparam int COORD_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd13124;

    // q16 scaling with round half up
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int PROD_W     = COORD_W + GAIN_W + 1;
    localparam int SCALED_W   = PROD_W - FRAC_BITS;

    // pixel to cell by reciprocal multiply, exact for pixel values below 1024
    localparam int PIX_W      = $clog2(IMAGE_W);
    localparam int DIV_SHIFT  = 16;
    localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + CELL_PIXELS - 1) / CELL_PIXELS;
    localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
    localparam int DIV_PROD_W = PIX_W + RECIP_W;
    localparam int DIV_Q_W    = DIV_PROD_W - DIV_SHIFT;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_POINT = 2'd1,
        KIND_END   = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_START = 2'd0,
        RES_END   = 2'd1,
        RES_QUERY = 2'd2
    } res_kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               keep;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } cell_item_t;

    typedef struct packed {
        res_kind_t          kind;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               blocked;
        logic               last;
    } result_t;

endpackage

// ----- src/ogsb_point_map.sv -----
// ----------------------------------------------------------------------------
// ogsb_point_map
// Three register stages that turn a scan point into a grid cell: input
// register, q16 gain multiply, then rounding, image clip and cell divide.
// ----------------------------------------------------------------------------
module ogsb_point_map
    import ogsb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  kind_t               in_kind,
    input  logic [COORD_W-1:0]  in_point_x,
    input  logic [COORD_W-1:0]  in_point_y,
    input  logic [COL_W-1:0]    in_query_col,
    input  logic [ROW_W-1:0]    in_query_row,
    input  logic [GAIN_W-1:0]   pixel_gain,
    output logic                out_valid,
    output cell_item_t          out_item
);

    logic                       a_valid_reg;
    kind_t                      a_kind_reg;
    logic signed [COORD_W-1:0]  a_x_reg;
    logic signed [COORD_W-1:0]  a_y_reg;
    logic [COL_W-1:0]           a_qcol_reg;
    logic [ROW_W-1:0]           a_qrow_reg;

    logic                       b_valid_reg;
    kind_t                      b_kind_reg;
    logic signed [PROD_W-1:0]   b_prod_x_reg;
    logic signed [PROD_W-1:0]   b_prod_y_reg;
    logic [COL_W-1:0]           b_qcol_reg;
    logic [ROW_W-1:0]           b_qrow_reg;

    logic                       c_valid_reg;
    cell_item_t                 c_item_reg;

    logic signed [PROD_W-1:0]   gain_s;
    logic signed [PROD_W-1:0]   prod_x_next;
    logic signed [PROD_W-1:0]   prod_y_next;

    logic signed [PROD_W-1:0]   round_x;
    logic signed [PROD_W-1:0]   round_y;
    logic signed [SCALED_W-1:0] scaled_x;
    logic signed [SCALED_W-1:0] scaled_y;
    logic signed [SCALED_W-1:0] px_full;
    logic                       in_image;
    logic [PIX_W-1:0]           px;
    logic [PIX_W-1:0]           py;
    logic [DIV_PROD_W-1:0]      col_prod;
    logic [DIV_PROD_W-1:0]      row_prod;
    logic [DIV_Q_W-1:0]         col_full;
    logic [DIV_Q_W-1:0]         row_full;
    cell_item_t                 c_item_next;

    assign gain_s      = PROD_W'($signed({1'b0, pixel_gain}));
    assign prod_x_next = PROD_W'(a_x_reg) * gain_s;
    assign prod_y_next = PROD_W'(a_y_reg) * gain_s;

    always_comb begin
        round_x  = b_prod_x_reg + PROD_W'(ROUND_HALF);
        round_y  = b_prod_y_reg + PROD_W'(ROUND_HALF);
        scaled_x = SCALED_W'(round_x >>> FRAC_BITS);
        scaled_y = SCALED_W'(round_y >>> FRAC_BITS);
        px_full  = scaled_x + SCALED_W'(CENTRE_X);
        in_image = (px_full >= 0) && (px_full < IMAGE_W) &&
                   (scaled_y >= 0) && (scaled_y < IMAGE_H);
        px       = px_full[PIX_W-1:0];
        py       = scaled_y[PIX_W-1:0];
        col_prod = DIV_PROD_W'(px) * DIV_PROD_W'(DIV_RECIP);
        row_prod = DIV_PROD_W'(py) * DIV_PROD_W'(DIV_RECIP);
        col_full = col_prod[DIV_PROD_W-1:DIV_SHIFT];
        row_full = row_prod[DIV_PROD_W-1:DIV_SHIFT];

        c_item_next.kind = b_kind_reg;
        if (b_kind_reg == KIND_QUERY) begin
            c_item_next.col  = b_qcol_reg;
            c_item_next.row  = b_qrow_reg;
            c_item_next.keep = (b_qcol_reg < GRID_W) && (b_qrow_reg < GRID_H);
        end else begin
            c_item_next.col  = col_full[COL_W-1:0];
            c_item_next.row  = row_full[ROW_W-1:0];
            c_item_next.keep = in_image && (col_full < GRID_W) && (row_full < GRID_H);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_kind_reg   <= in_kind;
            a_x_reg      <= in_point_x;
            a_y_reg      <= in_point_y;
            a_qcol_reg   <= in_query_col;
            a_qrow_reg   <= in_query_row;
            b_kind_reg   <= a_kind_reg;
            b_prod_x_reg <= prod_x_next;
            b_prod_y_reg <= prod_y_next;
            b_qcol_reg   <= a_qcol_reg;
            b_qrow_reg   <= a_qrow_reg;
            c_item_reg   <= c_item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

// ----- src/occupancy_grid_segment_builder.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_segment_builder
// Occupancy grid built from scan points, with cluster start and end cells
// reported as blocked segments break up, and single cell queries.
// ----------------------------------------------------------------------------
// path: input register, product register, cell register, then result queue
// throughput: one input beat per cycle while s_tready is high; a cluster break
//   or end of scan gives two result beats, which drain at one per cycle through
//   a 4-deep queue while m_tready is high; input stalls while over 2 beats are queued
// reset: synchronous active-low aresetn clears the grid, the cluster state and
//   the queue and loads pixel_gain with 13124
module occupancy_grid_segment_builder
    import ogsb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [GAIN_W-1:0]  cfg_wr_data,   // pixel_gain

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,       // point_x, point_y, query_col, query_row
    input  logic [1:0]         s_tuser,       // kind

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,       // cell_col, cell_row, cell_blocked
    output logic [1:0]         m_tuser,       // result_kind
    output logic               m_tlast
);

    logic [GAIN_W-1:0]   pixel_gain_reg;

    logic                adv;
    logic                c_valid;
    cell_item_t          item;
    logic                commit;

    logic [GRID_W-1:0]   grid_reg [GRID_H];

    logic                cluster_open_reg;
    logic                cluster_open_next;
    logic [COL_W-1:0]    start_col_reg;
    logic [COL_W-1:0]    start_col_next;
    logic [ROW_W-1:0]    start_row_reg;
    logic [ROW_W-1:0]    start_row_next;
    logic [COL_W-1:0]    prev_col_reg;
    logic [COL_W-1:0]    prev_col_next;
    logic [ROW_W-1:0]    prev_row_reg;
    logic [ROW_W-1:0]    prev_row_next;

    logic [ROW_W-1:0]    row_idx;
    logic [COL_W-1:0]    col_idx;
    logic                cell_bit;
    logic                is_robot;
    logic                place;
    logic                far;
    logic [COL_W:0]      col_x;
    logic [COL_W:0]      pcol_x;
    logic [ROW_W:0]      row_x;
    logic [ROW_W:0]      prow_x;
    logic [1:0]          push_n;
    result_t             res0;
    result_t             res1;

    result_t             q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic                pop;
    result_t             head;

    assign adv      = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign s_tready = adv;
    assign commit   = adv && c_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            pixel_gain_reg <= cfg_wr_data;
        end
    end

    ogsb_point_map u_map (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .in_kind      (kind_t'(s_tuser)),
        .in_point_x   (s_tdata[15:0]),
        .in_point_y   (s_tdata[31:16]),
        .in_query_col (s_tdata[37:32]),
        .in_query_row (s_tdata[42:38]),
        .pixel_gain   (pixel_gain_reg),
        .out_valid    (c_valid),
        .out_item     (item)
    );

    // grid lookup and cluster tracking
    always_comb begin
        row_idx  = item.keep ? item.row : '0;
        col_idx  = item.keep ? item.col : '0;
        cell_bit = item.keep && grid_reg[row_idx][col_idx];
        is_robot = (item.row == '0) && (item.col == COL_W'(ROBOT_COLUMN));
        place    = (item.kind == KIND_POINT) && item.keep && !cell_bit && !is_robot;

        col_x  = {1'b0, item.col};
        pcol_x = {1'b0, prev_col_reg};
        row_x  = {1'b0, item.row};
        prow_x = {1'b0, prev_row_reg};
        far    = (col_x > pcol_x + 1'b1) || (pcol_x > col_x + 1'b1) ||
                 (row_x > prow_x + 1'b1) || (prow_x > row_x + 1'b1);

        cluster_open_next = cluster_open_reg;
        start_col_next    = start_col_reg;
        start_row_next    = start_row_reg;
        prev_col_next     = prev_col_reg;
        prev_row_next     = prev_row_reg;
        push_n            = 2'd0;

        res0.kind    = RES_START;
        res0.col     = start_col_reg;
        res0.row     = start_row_reg;
        res0.blocked = 1'b0;
        res0.last    = 1'b0;
        res1.kind    = RES_END;
        res1.col     = prev_col_reg;
        res1.row     = prev_row_reg;
        res1.blocked = 1'b0;
        res1.last    = 1'b1;

        case (item.kind)
            KIND_START: begin
                cluster_open_next = 1'b0;
                prev_col_next     = '0;
                prev_row_next     = '0;
            end
            KIND_POINT: begin
                if (place) begin
                    if (!cluster_open_reg) begin
                        cluster_open_next = 1'b1;
                        start_col_next    = item.col;
                        start_row_next    = item.row;
                    end else if (far) begin
                        push_n         = 2'd2;
                        start_col_next = item.col;
                        start_row_next = item.row;
                    end
                    prev_col_next = item.col;
                    prev_row_next = item.row;
                end
            end
            KIND_END: begin
                if (cluster_open_reg) begin
                    push_n = 2'd2;
                end
                cluster_open_next = 1'b0;
                prev_col_next     = '0;
                prev_row_next     = '0;
            end
            KIND_QUERY: begin
                push_n       = 2'd1;
                res0.kind    = RES_QUERY;
                res0.col     = item.col;
                res0.row     = item.row;
                res0.blocked = cell_bit;
                res0.last    = 1'b1;
            end
            default: begin
                push_n = 2'd0;
            end
        endcase

        if (!commit) begin
            push_n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_open_reg <= 1'b0;
            start_col_reg    <= '0;
            start_row_reg    <= '0;
            prev_col_reg     <= '0;
            prev_row_reg     <= '0;
        end else if (commit) begin
            cluster_open_reg <= cluster_open_next;
            start_col_reg    <= start_col_next;
            start_row_reg    <= start_row_next;
            prev_col_reg     <= prev_col_next;
            prev_row_reg     <= prev_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < GRID_H; r++) begin
                grid_reg[r] <= '0;
            end
        end else if (commit) begin
            case (item.kind)
                KIND_START: begin
                    for (int r = 0; r < GRID_H; r++) begin
                        grid_reg[r] <= '0;
                    end
                end
                KIND_POINT: begin
                    if (place) begin
                        grid_reg[row_idx][col_idx] <= 1'b1;
                    end
                end
                KIND_END: begin
                    for (int r = 0; r < FRONT_BLOCK_ROWS; r++) begin
                        if (r < GRID_H && FRONT_COL_L >= 0 && FRONT_COL_L < GRID_W) begin
                            grid_reg[r][FRONT_COL_L] <= 1'b1;
                        end
                        if (r < GRID_H && FRONT_COL_R >= 0 && FRONT_COL_R < GRID_W) begin
                            grid_reg[r][FRONT_COL_R] <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result queue, up to two beats written per cycle
    assign head = q_reg[rd_ptr_reg];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(pop);
            count_reg  <= count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + Q_PTR_W'(1)] <= res1;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {4'd0, head.blocked, head.row, head.col};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule
